// ----- rtl/core/dewf_pkg.sv -----
// Package for the digitizer event word deframer.
// Shared types, codes and fixed stream constants; no dependencies.
package dewf_pkg;

  localparam logic [31:0] BUF_MARKER = 32'hABBAABBA;

  // Result kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_EVENT  = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_MARKER  = 2'd1;
  localparam logic [1:0] ERR_TRAILER = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_RAW_SAMPLES    = 3'd0;
  localparam logic [2:0] CFG_TRAP_WORDS     = 3'd1;
  localparam logic [2:0] CFG_WRAP_MODE      = 3'd2;
  localparam logic [2:0] CFG_TRAILER_MARKER = 3'd3;
  localparam logic [2:0] CFG_END_MARKER     = 3'd4;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_EVENT  = 5'b00010,
    PH_SKIP   = 5'b00100,
    PH_DONE   = 5'b01000,
    PH_ERROR  = 5'b10000
  } dewf_phase_t;

  typedef struct packed {
    logic [15:0] raw_samples;
    logic [15:0] trap_words;
    logic        wrap_mode;
    logic [31:0] trailer_marker;
    logic [31:0] end_marker;
  } dewf_cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        first_sample;
    logic [15:0]        second_sample;
    logic [15:0]        sample_position;
    logic [3:0]         channel_number;
    logic [47:0]        time_stamp;
    logic signed [31:0] energy_value;
    logic [1:0]         error_code;
  } dewf_result_t;

endpackage

// ----- rtl/core/dewf_cfg.sv -----
// Configuration register file of the event word deframer.
// Depends on dewf_pkg (register indexes, dewf_cfg_t).
module dewf_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [31:0]        wr_data,
  output dewf_pkg::dewf_cfg_t cfg
);
  import dewf_pkg::*;

  dewf_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_RAW_SAMPLES:    cfg_r.raw_samples    <= wr_data[15:0];
        CFG_TRAP_WORDS:     cfg_r.trap_words     <= wr_data[15:0];
        CFG_WRAP_MODE:      cfg_r.wrap_mode      <= wr_data[0];
        CFG_TRAILER_MARKER: cfg_r.trailer_marker <= wr_data;
        CFG_END_MARKER:     cfg_r.end_marker     <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/dewf_unwrap.sv -----
// Trace position of a raw sample pair, undoing the wrap by start index.
// Purely combinational; no package or submodule dependencies.
module dewf_unwrap (
  input  logic        wrap_mode,
  input  logic [14:0] trace_words,  // raw words per event
  input  logic [15:0] wrap_start,
  input  logic [14:0] word_index,   // raw word index within the trace
  output logic [15:0] position
);
  logic [15:0] k;
  logic [15:0] half;
  logic [15:0] half_min;
  logic [16:0] shift;
  logic [16:0] pos_late;
  logic [16:0] pos_early;

  always_comb begin
    k         = {word_index, 1'b0};
    half      = 16'(({1'b0, wrap_start} + 17'd1) >> 1);
    half_min  = (half > {1'b0, trace_words}) ? {1'b0, trace_words} : half;
    shift     = {half_min, 1'b0};
    pos_late  = {1'b0, k} - shift;
    // samples before the start index belong at the tail of the trace
    pos_early = {1'b0, trace_words, 1'b0} - shift + {1'b0, k};
    if (!wrap_mode)
      position = k;
    else if (k >= wrap_start)
      position = pos_late[15:0];
    else
      position = pos_early[15:0];
  end

endmodule

// ----- rtl/core/dewf_parse.sv -----
// Stream parser: buffer header, event packet tracking and result forming.
// Depends on dewf_pkg and dewf_unwrap.
module dewf_parse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,       // consume one word this cycle
  input  logic [31:0]            word,
  input  dewf_pkg::dewf_cfg_t    cfg,
  output logic                   res_valid,
  output dewf_pkg::dewf_result_t res
);
  import dewf_pkg::*;

  dewf_phase_t phase_r, phase_nxt;
  logic [16:0] wpos_r, wpos_nxt;
  logic [31:0] left_r, left_nxt;
  logic [3:0]  chan_r, chan_nxt;
  logic [47:0] time_r, time_nxt;
  logic [15:0] wstart_r, wstart_nxt;
  logic [31:0] energy_r, energy_nxt;

  logic [14:0] trace_words;
  logic [16:0] base;
  logic [16:0] pkt_len;
  logic [16:0] len_m1;
  logic [16:0] len_m4;
  logic [16:0] raw_end;
  logic [16:0] raw_off;
  logic [15:0] position;
  logic        skip_now;
  logic [31:0] left_dec;

  always_comb begin
    trace_words = cfg.raw_samples[15:1];
    base        = cfg.wrap_mode ? 17'd4 : 17'd2;
    pkt_len     = 17'd6 + {2'b0, trace_words} + {1'b0, cfg.trap_words}
                + (cfg.wrap_mode ? 17'd2 : 17'd0);
    len_m1      = pkt_len - 17'd1;
    len_m4      = pkt_len - 17'd4;
    raw_end     = base + {2'b0, trace_words};
    raw_off     = wpos_r - base;
    left_dec    = left_r - 32'd1;
  end

  dewf_unwrap u_unwrap (
    .wrap_mode   (cfg.wrap_mode),
    .trace_words (trace_words),
    .wrap_start  (wstart_r),
    .word_index  (raw_off[14:0]),
    .position    (position)
  );

  always_comb begin
    phase_nxt  = phase_r;
    wpos_nxt   = wpos_r;
    left_nxt   = left_r;
    chan_nxt   = chan_r;
    time_nxt   = time_r;
    wstart_nxt = wstart_r;
    energy_nxt = energy_r;
    res_valid  = 1'b0;
    res        = '0;
    skip_now   = 1'b0;

    if (step) begin
      case (phase_r)
        PH_HEADER: begin
          if (wpos_r == 17'd0) begin
            if (word == cfg.end_marker) begin
              phase_nxt = PH_DONE;
              res_valid = 1'b1;
              res.kind  = KIND_END;
            end else if (word != BUF_MARKER) begin
              phase_nxt      = PH_ERROR;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_MARKER;
            end else begin
              wpos_nxt = 17'd1;
            end
          end else if (wpos_r < 17'd3) begin
            wpos_nxt = wpos_r + 17'd1;
          end else begin
            left_nxt  = word;
            wpos_nxt  = '0;
            phase_nxt = (word != 32'd0) ? PH_EVENT : PH_HEADER;
          end
        end

        PH_EVENT, PH_SKIP: begin
          // too few words left for a whole packet: drop rest of buffer
          skip_now = (phase_r == PH_SKIP) ||
                     ((wpos_r == 17'd0) && (left_r < {15'd0, pkt_len}));
          phase_nxt = skip_now ? PH_SKIP : PH_EVENT;

          if (!skip_now) begin
            if (wpos_r == 17'd0) begin
              chan_nxt = {1'b0, word[2:0]} + 4'd1;
              time_nxt = {word[31:16], 32'd0};
            end else if (wpos_r == 17'd1) begin
              time_nxt = {time_r[47:32], word};
            end else if (cfg.wrap_mode && wpos_r == 17'd3) begin
              wstart_nxt = (word[31:16] != 16'd0) ? 16'hFFFF : word[15:0];
            end else if (wpos_r >= base && wpos_r < raw_end) begin
              res_valid           = 1'b1;
              res.kind            = KIND_SAMPLE;
              res.first_sample    = word[31:16];
              res.second_sample   = word[15:0];
              res.sample_position = position;
            end else if (wpos_r == len_m4) begin
              energy_nxt = word;
            end

            if (wpos_r >= len_m1) begin
              wpos_nxt = '0;
              if (word != cfg.trailer_marker) begin
                phase_nxt      = PH_ERROR;
                res            = '0;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_TRAILER;
              end else begin
                res.kind           = KIND_EVENT;
                res.channel_number = chan_r;
                res.time_stamp     = time_r;
                res.energy_value   = energy_r;
              end
              res_valid = 1'b1;
            end else begin
              wpos_nxt = wpos_r + 17'd1;
            end
          end

          if (phase_nxt != PH_ERROR) begin
            left_nxt = left_dec;
            if (left_dec == 32'd0) begin
              phase_nxt = PH_HEADER;
              wpos_nxt  = '0;
            end
          end
        end

        PH_DONE, PH_ERROR: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      wpos_r   <= '0;
      left_r   <= '0;
      chan_r   <= '0;
      time_r   <= '0;
      wstart_r <= '0;
      energy_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      wpos_r   <= wpos_nxt;
      left_r   <= left_nxt;
      chan_r   <= chan_nxt;
      time_r   <= time_nxt;
      wstart_r <= wstart_nxt;
      energy_r <= energy_nxt;
    end
  end

endmodule

// ----- rtl/core/digitizer_event_word_deframer.sv -----
// Digitizer event word deframer, top level.
// Depends on dewf_pkg, dewf_cfg, dewf_parse (which uses dewf_unwrap).
//
// Takes the digitizer stream one 32-bit word per in_ transfer: buffers of a
// four-word header (marker, two ignored words, length) followed by fixed-length
// event packets. Every raw trace word gives one sample-pair result tagged with
// its final trace position (a wrapped trace comes out with the correct indexes,
// no reordering buffer), and every good trailer gives an event record with
// channel, 48-bit timestamp and signed energy. Header words, timestamps,
// trapezoid words and buffer leftovers too short for a whole packet give no
// result. The end marker gives one end-of-data result; a bad buffer marker or a
// missing trailer gives one error result; after either the block takes and
// drops every word until reset.
// Rate: one word per cycle, sustained. The word sits in an input register, is
// parsed in one register-to-register pass (position counters, packet length
// add and compares, the unwrap subtract), and its result lands in the output
// register. The output register holds a waiting result while the next word is
// taken in; backpressure on out_ready stalls the input only when both
// registers are full.
// Configuration: cfg_ready is always high; index 0 raw_samples, 1 trap_words,
// 2 wrap_mode, 3 trailer_marker, 4 end_marker; other indexes are ignored.
// Write registers only while no words are in flight.
module digitizer_event_word_deframer (
  input  logic               clk,
  input  logic               rst_n,
  // word input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_data_word,
  // result output
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [15:0]        out_first_sample,
  output logic [15:0]        out_second_sample,
  output logic [15:0]        out_sample_position,
  output logic [3:0]         out_channel_number,
  output logic [47:0]        out_time_stamp,
  output logic signed [31:0] out_energy_value,
  output logic [1:0]         out_error_code,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import dewf_pkg::*;

  dewf_cfg_t    cfg;
  dewf_result_t res;
  logic         res_valid;

  // input register
  logic         in_valid_r, in_valid_nxt;
  logic [31:0]  in_word_r;

  // output register
  logic         out_valid_r, out_valid_nxt;
  dewf_result_t out_res_r;

  logic         advance;   // parse the held word this cycle

  assign cfg_ready = 1'b1;

  dewf_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // a word moves on when the output register is free or being drained
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  dewf_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .word      (in_word_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    in_valid_nxt = (in_valid && in_ready) ? 1'b1 : (in_valid_r && !advance);
    if (advance)
      out_valid_nxt = res_valid;
    else
      out_valid_nxt = out_valid_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready)
      in_word_r <= in_data_word;
    if (advance && res_valid)
      out_res_r <= res;
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_res_r.kind;
  assign out_first_sample    = out_res_r.first_sample;
  assign out_second_sample   = out_res_r.second_sample;
  assign out_sample_position = out_res_r.sample_position;
  assign out_channel_number  = out_res_r.channel_number;
  assign out_time_stamp      = out_res_r.time_stamp;
  assign out_energy_value    = out_res_r.energy_value;
  assign out_error_code      = out_res_r.error_code;

endmodule

// ----- rtl/core/dewf_checker.sv -----
// Port-level checks for the event word deframer, bound to the top level.
// Depends on dewf_pkg (result kinds, error codes).
module dewf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_kind,
  input logic [15:0]        out_sample_position,
  input logic [3:0]         out_channel_number,
  input logic [47:0]        out_time_stamp,
  input logic [1:0]         out_error_code
);
  import dewf_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_sample_position) && $stable(out_time_stamp))
    else $error("result changed while stalled");

  // end of data and errors halt the block until reset
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_kind == KIND_END || out_kind == KIND_ERROR)
      |=> !out_valid)
    else $error("result after halt");

  // error code set exactly on error results
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == KIND_ERROR) == (out_error_code != ERR_NONE)))
    else $error("error code does not match kind");

  // event records carry channel 1 to 8
  a_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_EVENT |->
      out_channel_number != 4'd0 && out_channel_number <= 4'd8)
    else $error("event channel out of range");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind digitizer_event_word_deframer dewf_checker u_dewf_checker (.*);
